// ===== rtl/mta_pkg.sv =====
// ---------------------------------------------------------------------------
// mta_pkg
// Shared types and constants for the motion and tamper alarm block.
// ---------------------------------------------------------------------------
package mta_pkg;

   localparam int WindowDefault = 16;

   localparam int SampleW  = 16;
   localparam int SumW     = 24;
   localparam int ThrW     = 15;
   localparam int PersistW = 8;
   localparam int CsrDataW = 15;
   localparam int CsrIdxW  = 2;

   localparam logic [CsrIdxW-1:0] CsrThresholdX   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrThresholdY   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrPersistLimit = 2'd2;

   localparam logic [ThrW-1:0]     ThresholdReset    = 15'd4096;
   localparam logic [PersistW-1:0] PersistLimitReset = 8'd7;
   localparam logic [PersistW-1:0] PersistMax        = 8'd255;

   typedef struct packed {
      logic signed [SampleW-1:0] sample_x;
      logic signed [SampleW-1:0] sample_y;
      logic                      bypass;
      logic                      package_present;
      logic                      claw_closed;
   } req_type;

   typedef struct packed {
      logic alarm;
      logic motion_alarm;
      logic package_alarm;
      logic window_end;
   } rsp_type;

   // per-transaction command from the merge stage to the axis lanes
   typedef struct packed {
      logic advance;   // transaction accepted, add the sample
      logic clear;     // this sample closes the window
   } lane_ctrl_type;

endpackage

// ===== rtl/mta_lane.sv =====
// ---------------------------------------------------------------------------
// mta_lane
// One axis lane: saturating window sum and magnitude-over-threshold test.
// ---------------------------------------------------------------------------
module mta_lane #(
   parameter int WINDOW = mta_pkg::WindowDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mta_pkg::lane_ctrl_type            ctrl,
   input  logic signed [mta_pkg::SampleW-1:0] sample,
   input  logic [mta_pkg::ThrW-1:0]          threshold,
   output logic                              over
);

   localparam int SumW  = mta_pkg::SumW;
   localparam int CntW  = $clog2(WINDOW + 1);
   localparam int ProdW = mta_pkg::ThrW + CntW;
   localparam int CmpW  = (ProdW > SumW) ? ProdW : SumW;

   logic signed [SumW-1:0] sum_ff, sum_in;
   logic signed [SumW:0]   sum_wide;
   logic signed [SumW-1:0] sum_sat;
   logic [SumW-1:0]        mag;
   logic [ProdW-1:0]       limit;

   assign sum_wide = {sum_ff[SumW-1], sum_ff}
                   + {{(SumW + 1 - mta_pkg::SampleW){sample[mta_pkg::SampleW-1]}}, sample};

   // clamp when the two top bits disagree
   always_comb begin
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end
   end

   // most negative sum maps to its true magnitude as unsigned
   assign mag   = sum_sat[SumW-1] ? (~sum_sat + 1'b1) : sum_sat;
   assign limit = {{CntW{1'b0}}, threshold} * ProdW'(WINDOW);
   assign over  = CmpW'(mag) > CmpW'(limit);

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.advance) begin
         sum_in = ctrl.clear ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== rtl/mta_merge.sv =====
// ---------------------------------------------------------------------------
// mta_merge
// Window position, persistence counter and registered result stage.
// ---------------------------------------------------------------------------
module mta_merge #(
   parameter int WINDOW = mta_pkg::WindowDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  mta_pkg::req_type               req,
   input  logic                           over_x,
   input  logic                           over_y,
   input  logic [mta_pkg::PersistW-1:0]   persist_limit,
   output mta_pkg::lane_ctrl_type         lane_ctrl,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mta_pkg::rsp_type               rsp_data
);

   localparam int CntW = $clog2(WINDOW + 1);

   logic [CntW-1:0]             count_ff, count_in;
   logic [CntW-1:0]             count_inc;
   logic [mta_pkg::PersistW-1:0] persist_ff, persist_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mta_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                        wend;
   logic                        motion;
   logic                        pkg;

   assign count_inc = count_ff + 1'b1;
   assign wend      = !req.bypass && (count_inc >= CntW'(WINDOW));
   assign pkg       = req.package_present && !req.claw_closed;

   assign lane_ctrl.advance = accept;
   assign lane_ctrl.clear   = wend;

   always_comb begin
      count_in   = count_ff;
      persist_in = persist_ff;
      motion     = 1'b0;
      if (!req.bypass) begin
         count_in = wend ? '0 : count_inc;
      end
      if (wend) begin
         if (over_x || over_y) begin
            persist_in = (persist_ff < mta_pkg::PersistMax) ? persist_ff + 1'b1 : persist_ff;
            motion     = persist_in > persist_limit;
         end else begin
            persist_in = '0;
         end
      end
   end

   always_comb begin
      rsp_data_in.alarm         = motion || pkg;
      rsp_data_in.motion_alarm  = motion;
      rsp_data_in.package_alarm = pkg;
      rsp_data_in.window_end    = wend;
      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         persist_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff   <= count_in;
            persist_ff <= persist_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/motion_tamper_alarm_unit.sv =====
// ---------------------------------------------------------------------------
// motion_tamper_alarm_unit
// Accelerometer motion alarm with package tamper detection. Each transaction
// carries one X and one Y sample; an X lane and a Y lane each keep a
// saturating window sum and test it against threshold * WINDOW, and a merge
// stage tracks window position and consecutive moving windows. One
// transaction is accepted every cycle unless the result is stalled; its
// result appears in the output register on the next cycle, from the
// combinational lane add, abs and compare path. A new transaction is taken
// whenever the output register is empty or being drained in the same cycle.
// ---------------------------------------------------------------------------
module motion_tamper_alarm_unit #(
   parameter int WINDOW = mta_pkg::WindowDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mta_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mta_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [mta_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mta_pkg::CsrDataW-1:0]  csr_wdata
);

   logic [mta_pkg::ThrW-1:0]     thr_x_ff, thr_x_in;
   logic [mta_pkg::ThrW-1:0]     thr_y_ff, thr_y_in;
   logic [mta_pkg::PersistW-1:0] limit_ff, limit_in;
   logic                         accept;
   logic                         over_x;
   logic                         over_y;
   mta_pkg::lane_ctrl_type       lane_ctrl;

   assign req_ready = !reset && (!rsp_valid || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      thr_x_in = thr_x_ff;
      thr_y_in = thr_y_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index)
            mta_pkg::CsrThresholdX:   thr_x_in = csr_wdata[mta_pkg::ThrW-1:0];
            mta_pkg::CsrThresholdY:   thr_y_in = csr_wdata[mta_pkg::ThrW-1:0];
            mta_pkg::CsrPersistLimit: limit_in = csr_wdata[mta_pkg::PersistW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_x_ff <= mta_pkg::ThresholdReset;
         thr_y_ff <= mta_pkg::ThresholdReset;
         limit_ff <= mta_pkg::PersistLimitReset;
      end else begin
         thr_x_ff <= thr_x_in;
         thr_y_ff <= thr_y_in;
         limit_ff <= limit_in;
      end
   end

   mta_lane #(.WINDOW(WINDOW)) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .sample    (req_data.sample_x),
      .threshold (thr_x_ff),
      .over      (over_x)
   );

   mta_lane #(.WINDOW(WINDOW)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .sample    (req_data.sample_y),
      .threshold (thr_y_ff),
      .over      (over_y)
   );

   mta_merge #(.WINDOW(WINDOW)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_data),
      .over_x        (over_x),
      .over_y        (over_y),
      .persist_limit (limit_ff),
      .lane_ctrl     (lane_ctrl),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== rtl/mta_checker.sv =====
// ---------------------------------------------------------------------------
// mta_checker
// Port-level checks for the motion and tamper alarm block.
// ---------------------------------------------------------------------------
module mta_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mta_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mta_pkg::rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_alarm_or: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.alarm == (rsp_data.motion_alarm || rsp_data.package_alarm))
      else $error("alarm is not motion or package alarm");

   a_motion_on_wend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motion_alarm |-> rsp_data.window_end)
      else $error("motion alarm outside a window end");

   // each accepted transaction shows up next cycle with its package flag
   a_next_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid
         && rsp_data.package_alarm ==
            ($past(req_data.package_present) && !$past(req_data.claw_closed))
         && (!$past(req_data.bypass) || !rsp_data.window_end))
      else $error("result does not follow accepted transaction");

endmodule

bind motion_tamper_alarm_unit mta_checker u_mta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/tb_motion_tamper_alarm_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_motion_tamper_alarm_unit
// Self-checking bench for the motion and tamper alarm block. Drives sample
// transactions through valid/ready with random idling on both sides, keeps
// a cycle-free model of the window sums, persistence counter and package
// flag, and compares every result transaction field by field in order.
// Thresholds and the persistence limit are reprogrammed between phases,
// while the block is idle.
// ---------------------------------------------------------------------------
module tb_motion_tamper_alarm_unit;

   localparam int SampleW  = mta_pkg::SampleW;
   localparam int SumW     = mta_pkg::SumW;
   localparam int ThrW     = mta_pkg::ThrW;
   localparam int PersistW = mta_pkg::PersistW;
   localparam int CsrDataW = mta_pkg::CsrDataW;
   localparam int CsrIdxW  = mta_pkg::CsrIdxW;

   localparam int Window        = mta_pkg::WindowDefault;
   localparam int SumMax        = (1 << (SumW - 1)) - 1;
   localparam int SumMin        = -(1 << (SumW - 1));
   localparam int SampleMax     = (1 << (SampleW - 1)) - 1;
   localparam int SampleMin     = -(1 << (SampleW - 1));
   localparam int ThrMax        = (1 << ThrW) - 1;
   localparam int SettleCycles  = 4;
   localparam int WatchdogLimit = 2000;

   // index past the last register, writes there must be dropped
   localparam logic [CsrIdxW-1:0] CsrSpare = 2'd3;

   typedef enum int {WinQuiet, WinNear, WinLoud, WinWild} win_kind_type;

   // ------------------------------------------------------------------------
   class alarm_scoreboard;
      logic [ThrW-1:0]        thr_x;
      logic [ThrW-1:0]        thr_y;
      logic [PersistW-1:0]    limit;
      logic signed [SumW-1:0] acc_x;
      logic signed [SumW-1:0] acc_y;
      int                     win_pos;
      logic [PersistW-1:0]    moving_windows;
      mta_pkg::rsp_type       expected_alarms[$];
      int                     errors;
      int                     n_samples;
      int                     n_windows;
      int                     n_motion;
      int                     n_package;

      function new();
         thr_x          = mta_pkg::ThresholdReset;
         thr_y          = mta_pkg::ThresholdReset;
         limit          = mta_pkg::PersistLimitReset;
         acc_x          = '0;
         acc_y          = '0;
         win_pos        = 0;
         moving_windows = '0;
         errors         = 0;
         n_samples      = 0;
         n_windows      = 0;
         n_motion       = 0;
         n_package      = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            mta_pkg::CsrThresholdX:   thr_x = data[ThrW-1:0];
            mta_pkg::CsrThresholdY:   thr_y = data[ThrW-1:0];
            mta_pkg::CsrPersistLimit: limit = data[PersistW-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [SumW-1:0] add_sat(logic signed [SumW-1:0] acc,
                                               logic signed [SampleW-1:0] s);
         int t;
         t = int'(acc) + int'(s);
         if (t > SumMax) t = SumMax;
         if (t < SumMin) t = SumMin;
         return t[SumW-1:0];
      endfunction

      // |sum| > thr * Window, exact integer form of the average test
      function bit exceeds(logic signed [SumW-1:0] acc, logic [ThrW-1:0] thr);
         int mag;
         mag = (acc < 0) ? -int'(acc) : int'(acc);
         return mag > int'(thr) * Window;
      endfunction

      function mta_pkg::rsp_type predict_alarm(mta_pkg::req_type s);
         mta_pkg::rsp_type r;
         bit               motion;
         r      = '0;
         motion = 1'b0;
         acc_x  = add_sat(acc_x, s.sample_x);
         acc_y  = add_sat(acc_y, s.sample_y);
         if (!s.bypass) begin
            win_pos++;
            if (win_pos >= Window) begin
               r.window_end = 1'b1;
               if (exceeds(acc_x, thr_x) || exceeds(acc_y, thr_y)) begin
                  if (moving_windows != mta_pkg::PersistMax) moving_windows++;
                  motion = moving_windows > limit;
               end else begin
                  moving_windows = '0;
               end
               acc_x   = '0;
               acc_y   = '0;
               win_pos = 0;
            end
         end
         r.package_alarm = s.package_present & ~s.claw_closed;
         r.motion_alarm  = motion;
         r.alarm         = motion | r.package_alarm;
         return r;
      endfunction

      function void note_sample(mta_pkg::req_type s);
         expected_alarms.push_back(predict_alarm(s));
         n_samples++;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_alarm(mta_pkg::rsp_type got);
         mta_pkg::rsp_type want;
         if (expected_alarms.size() == 0) begin
            report_mismatch($sformatf("result %b with no transaction pending", got));
            return;
         end
         want = expected_alarms.pop_front();
         if (got.alarm !== want.alarm)
            report_mismatch($sformatf("alarm %b, predicted %b", got.alarm, want.alarm));
         if (got.motion_alarm !== want.motion_alarm)
            report_mismatch($sformatf("motion_alarm %b, predicted %b",
                                      got.motion_alarm, want.motion_alarm));
         if (got.package_alarm !== want.package_alarm)
            report_mismatch($sformatf("package_alarm %b, predicted %b",
                                      got.package_alarm, want.package_alarm));
         if (got.window_end !== want.window_end)
            report_mismatch($sformatf("window_end %b, predicted %b",
                                      got.window_end, want.window_end));
         if (want.window_end)    n_windows++;
         if (want.motion_alarm)  n_motion++;
         if (want.package_alarm) n_package++;
      endtask

      function int pending();
         return expected_alarms.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   mta_pkg::req_type     req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   mta_pkg::rsp_type     rsp_data;
   logic                 csr_write = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   alarm_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int gen_pos        = 0;   // non-bypass samples into the current window
   int sent_count     = 0;
   int quiet_cycles   = 0;

   motion_tamper_alarm_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor, scoreboard hookup and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_write) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_alarm(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_motion_tamper_alarm_unit NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   function automatic logic signed [SampleW-1:0] clip_sample(int v);
      if (v > SampleMax) v = SampleMax;
      if (v < SampleMin) v = SampleMin;
      return v[SampleW-1:0];
   endfunction

   function automatic mta_pkg::req_type make_sample(int x, int y, bit byp, bit present,
                                                    bit claw);
      mta_pkg::req_type item;
      item.sample_x        = clip_sample(x);
      item.sample_y        = clip_sample(y);
      item.bypass          = byp;
      item.package_present = present;
      item.claw_closed     = claw;
      return item;
   endfunction

   function automatic mta_pkg::req_type random_item();
      mta_pkg::req_type item;
      item = mta_pkg::req_type'({$urandom, $urandom});
      item.bypass          = $urandom_range(1);
      item.package_present = $urandom_range(1);
      item.claw_closed     = $urandom_range(1);
      return item;
   endfunction

   function automatic int level_for(win_kind_type k, logic [ThrW-1:0] thr);
      int t;
      t = int'(thr);
      case (k)
         WinQuiet: return $urandom_range(t / 2);
         WinNear:  return t - 24 + $urandom_range(48);
         WinLoud:  return t + $urandom_range(SampleMax - t);
         default:  return $urandom_range(SampleMax);
      endcase
   endfunction

   task automatic send_sample(mta_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (!item.bypass) gen_pos = (gen_pos + 1) % Window;
   endtask

   // fills the current window; bypass transactions are sometimes mixed in
   task automatic send_window(win_kind_type k);
      mta_pkg::req_type item;
      int               lx;
      int               ly;
      int               sx;
      int               sy;
      bit               sprinkle;
      lx       = level_for(k, sb.thr_x);
      ly       = level_for(k, sb.thr_y);
      sx       = $urandom_range(1) ? 1 : -1;
      sy       = $urandom_range(1) ? 1 : -1;
      sprinkle = ($urandom_range(4) == 0);
      do begin
         if (sprinkle && $urandom_range(9) == 0) begin
            item        = random_item();
            item.bypass = 1'b1;
         end else if (k == WinWild) begin
            item        = random_item();
            item.bypass = 1'b0;
         end else begin
            item = make_sample(sx * lx + $urandom_range(63) - 32,
                               sy * ly + $urandom_range(63) - 32,
                               1'b0, $urandom_range(1), $urandom_range(1));
         end
         send_sample(item);
      end while (gen_pos != 0);
   endtask

   // window whose sum sits exactly on the threshold, optionally one unit past it
   task automatic send_edge_window();
      int thr;
      int sgn;
      int bump_at;
      int v;
      bit use_x;
      bit bump;
      if (gen_pos != 0) send_window(WinQuiet);
      use_x   = $urandom_range(1);
      thr     = use_x ? int'(sb.thr_x) : int'(sb.thr_y);
      sgn     = $urandom_range(1) ? 1 : -1;
      bump    = $urandom_range(1);
      bump_at = $urandom_range(Window - 1);
      if (bump && thr + 1 > SampleMax) sgn = -1;
      for (int i = 0; i < Window; i++) begin
         v = sgn * (thr + ((bump && i == bump_at) ? 1 : 0));
         send_sample(make_sample(use_x ? v : 0, use_x ? 0 : v, 1'b0,
                                 $urandom_range(1), $urandom_range(1)));
      end
   endtask

   // long bypass stretch drives both sums into saturation, then closes the window
   task automatic send_bypass_run(bit negative);
      repeat (270) begin
         send_sample(make_sample(negative ? SampleMin : SampleMax,
                                 negative ? SampleMax : SampleMin, 1'b1,
                                 $urandom_range(1), $urandom_range(1)));
      end
      send_window(WinQuiet);
   endtask

   task automatic run_random(int n_items);
      int start;
      int pick;
      start = sent_count;
      while (sent_count - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_window(win_kind_type'($urandom_range(3)));
         else if (pick < 75)
            send_edge_window();
         else
            send_sample(random_item());
      end
   endtask

   task automatic run_directed();
      send_sample(make_sample(SampleMax, SampleMin, 1'b0, 1'b1, 1'b0));
      send_sample(make_sample(SampleMin, SampleMax, 1'b0, 1'b1, 1'b1));
      send_sample(make_sample(0, 0, 1'b0, 1'b0, 1'b0));
      send_sample(make_sample(-1, 1, 1'b0, 1'b0, 1'b1));
      send_sample(make_sample(SampleMax, SampleMax, 1'b1, 1'b1, 1'b0));
      send_sample(make_sample(SampleMin, SampleMin, 1'b1, 1'b0, 1'b0));
      repeat (11)
         send_sample(make_sample(SampleMax, 0, 1'b0, $urandom_range(1), $urandom_range(1)));
      // bypass on the slot that would close the window
      send_sample(make_sample(1000, 1000, 1'b1, 1'b1, 1'b0));
      send_sample(make_sample(SampleMax, -5, 1'b0, 1'b0, 1'b0));
   endtask

   task automatic program_regs(logic [ThrW-1:0] tx, logic [ThrW-1:0] ty,
                               logic [PersistW-1:0] pl);
      logic [CsrDataW-1:0] w;
      csr_write <= 1'b1;
      csr_index <= mta_pkg::CsrThresholdX;
      csr_wdata <= CsrDataW'(tx);
      @(posedge clock);
      csr_index <= mta_pkg::CsrThresholdY;
      csr_wdata <= CsrDataW'(ty);
      @(posedge clock);
      // junk above the register width must be dropped
      w              = CsrDataW'($urandom);
      w[PersistW-1:0] = pl;
      csr_index <= mta_pkg::CsrPersistLimit;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CsrSpare;
      csr_wdata <= CsrDataW'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_idle();

      program_regs(15'd1000, 15'd200, 8'd2);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_bypass_run(1'b0);
      run_random(70);
      wait_idle();

      program_regs('0, '0, '0);
      send_idle_pct  = 76;
      recv_stall_pct = 0;
      run_random(70);
      wait_idle();

      program_regs(ThrW'(ThrMax), ThrW'(ThrMax), mta_pkg::PersistMax);
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      run_random(70);
      wait_idle();

      program_regs(ThrW'($urandom_range(ThrMax)), ThrW'($urandom_range(3000)),
                   PersistW'($urandom_range(5)));
      send_idle_pct  = 31;
      recv_stall_pct = 31;
      run_random(70);
      wait_idle();

      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d predicted results never arrived", sb.pending()));

      $display("covered %0d transactions: %0d window closes, %0d motion alarms,",
               sb.n_samples, sb.n_windows, sb.n_motion);
      $display("%0d package alarms, five register settings, four idling mixes, %0d mismatches",
               sb.n_package, sb.errors);
      if (sb.errors == 0)
         $display("tb_motion_tamper_alarm_unit OK");
      else
         $display("tb_motion_tamper_alarm_unit NOT OK");
      $finish;
   end

endmodule
